[src/frjb_pkg.sv]
// Package for the feed rotor jam backoff controller.
// Holds the item, state, result and configuration types, codes and saturation helper.
// No dependencies.
package frjb_pkg;

	typedef enum logic [1:0] {
		MODE_DISABLED = 2'd0,
		MODE_NORMAL   = 2'd1,
		MODE_BACKOFF  = 2'd2
	} mode_t;

	localparam logic [1:0] FUNC_TICK    = 2'd0;
	localparam logic [1:0] FUNC_ENABLE  = 2'd1;
	localparam logic [1:0] FUNC_DISABLE = 2'd2;

	localparam logic [1:0] CMD_NONE  = 2'd0;
	localparam logic [1:0] CMD_START = 2'd1;
	localparam logic [1:0] CMD_STOP  = 2'd2;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 24;

	localparam logic [CFG_INDEX_W-1:0] CFG_SHOT_ANGLE        = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_JAM_TORQUE_LIMIT  = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_JAM_TIME_US       = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_BACKOFF_ANGLE     = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_BACKOFF_TOLERANCE = 3'd4;

	typedef struct packed {
		logic signed [17:0] shot_angle;
		logic [14:0]        jam_torque_limit;
		logic [23:0]        jam_time_us;
		logic [16:0]        backoff_angle;
		logic [16:0]        backoff_tolerance;
	} cfg_t;

	typedef struct packed {
		logic [1:0]         func;
		logic [15:0]        shot_count;
		logic signed [31:0] motor_angle;
		logic signed [15:0] motor_torque;
		logic [15:0]        tick_time_us;
	} item_t;

	typedef struct packed {
		mode_t              mode;
		logic signed [31:0] target_angle;
		logic [15:0]        handled_sequence;
		logic [31:0]        jam_timer;
	} state_t;

	typedef struct packed {
		logic signed [31:0] motor_ref;
		logic               ref_valid;
		logic [1:0]         motor_command;
		mode_t              mode;
	} result_t;

	function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
		logic signed [31:0] r;
		if (v > 36'sd2147483647) begin
			r = 32'sh7FFFFFFF;
		end else if (v < -36'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage

[src/frjb_cfg_regs.sv]
// Configuration register bank of the feed rotor jam backoff controller.
// Depends on frjb_pkg for the register indexes and the configuration struct.
module frjb_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [frjb_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [frjb_pkg::CFG_DATA_W-1:0]  cfg_data,
	output frjb_pkg::cfg_t                   cfg
);
	import frjb_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.shot_angle        <= 18'sd11520;
			cfg_q.jam_torque_limit  <= 15'd10000;
			cfg_q.jam_time_us       <= 24'd500000;
			cfg_q.backoff_angle     <= 17'd7680;
			cfg_q.backoff_tolerance <= 17'd512;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SHOT_ANGLE:        cfg_q.shot_angle        <= cfg_data[17:0];
				CFG_JAM_TORQUE_LIMIT:  cfg_q.jam_torque_limit  <= cfg_data[14:0];
				CFG_JAM_TIME_US:       cfg_q.jam_time_us       <= cfg_data[23:0];
				CFG_BACKOFF_ANGLE:     cfg_q.backoff_angle     <= cfg_data[16:0];
				CFG_BACKOFF_TOLERANCE: cfg_q.backoff_tolerance <= cfg_data[16:0];
				default: ;
			endcase
		end
	end

endmodule

[src/frjb_update.sv]
// Next-state and result logic for one item of the feed rotor jam backoff controller.
// Depends on frjb_pkg for the item, state, result and configuration types.
module frjb_update (
	input  frjb_pkg::item_t   item,
	input  frjb_pkg::state_t  st,
	input  frjb_pkg::cfg_t    cfg,
	output frjb_pkg::state_t  st_next,
	output frjb_pkg::result_t res
);
	import frjb_pkg::*;

	logic [15:0]        delta;
	logic signed [34:0] prod;
	logic signed [35:0] adv_sum;
	logic signed [31:0] adv_target;
	logic [15:0]        torque_mag;
	logic               over_torque;
	logic [32:0]        timer_sum;
	logic [31:0]        timer_acc;
	logic               jam;
	logic signed [35:0] angle_ext;
	logic signed [35:0] backoff_sum;
	logic signed [31:0] backoff_target;
	logic signed [32:0] err;
	logic signed [32:0] tol;

	always_comb begin
		delta = item.shot_count - st.handled_sequence;
		prod = $signed({1'b0, delta}) * cfg.shot_angle;
		adv_sum = {{4{st.target_angle[31]}}, st.target_angle} + {prod[34], prod};
		adv_target = sat32(adv_sum);

		torque_mag = item.motor_torque[15] ? 16'(-item.motor_torque)
			: item.motor_torque[15:0];
		over_torque = torque_mag >= {1'b0, cfg.jam_torque_limit};
		timer_sum = {1'b0, st.jam_timer} + {17'd0, item.tick_time_us};
		if (!over_torque) begin
			timer_acc = 32'd0;
		end else if (timer_sum[32]) begin
			timer_acc = 32'hFFFFFFFF;
		end else begin
			timer_acc = timer_sum[31:0];
		end
		jam = timer_acc >= {8'd0, cfg.jam_time_us};

		angle_ext = {{4{item.motor_angle[31]}}, item.motor_angle};
		if (cfg.shot_angle > 18'sd0) begin
			backoff_sum = angle_ext - {19'd0, cfg.backoff_angle};
		end else if (cfg.shot_angle < 18'sd0) begin
			backoff_sum = angle_ext + {19'd0, cfg.backoff_angle};
		end else begin
			backoff_sum = angle_ext;
		end
		backoff_target = sat32(backoff_sum);

		err = {st.target_angle[31], st.target_angle} - {item.motor_angle[31], item.motor_angle};
		tol = {16'd0, cfg.backoff_tolerance};

		st_next = st;
		res.ref_valid = 1'b0;
		res.motor_command = CMD_NONE;

		case (item.func)
			FUNC_ENABLE: begin
				st_next.target_angle = item.motor_angle;
				st_next.handled_sequence = item.shot_count;
				st_next.jam_timer = 32'd0;
				st_next.mode = MODE_NORMAL;
				res.motor_command = CMD_START;
			end
			FUNC_DISABLE: begin
				st_next.jam_timer = 32'd0;
				st_next.mode = MODE_DISABLED;
				res.motor_command = CMD_STOP;
			end
			FUNC_TICK: begin
				case (st.mode)
					MODE_NORMAL: begin
						st_next.handled_sequence = item.shot_count;
						res.ref_valid = 1'b1;
						if (jam) begin
							st_next.target_angle = backoff_target;
							st_next.jam_timer = 32'd0;
							st_next.mode = MODE_BACKOFF;
						end else begin
							st_next.target_angle = adv_target;
							st_next.jam_timer = timer_acc;
						end
					end
					MODE_BACKOFF: begin
						res.ref_valid = 1'b1;
						if (err <= tol && err >= -tol) begin
							st_next.mode = MODE_NORMAL;
						end
					end
					default: ;
				endcase
			end
			default: ;
		endcase

		res.motor_ref = res.ref_valid ? st_next.target_angle : 32'sd0;
		res.mode = st_next.mode;
	end

endmodule

[src/feed_rotor_jam_backoff_control.sv]
// Top level of the feed rotor jam backoff controller.
// Depends on frjb_pkg, frjb_cfg_regs and frjb_update.
//
// Items arrive on the s_ stream: s_tuser carries func and s_tdata the shot
// count, motor angle, motor torque and tick time. Every item gives exactly
// one result on the m_ stream: m_tuser carries ref_valid and m_tdata the
// motor reference, motor command and mode.
// A transaction on the s_ side lands in the input register; the item is then
// evaluated against the controller state and the result register is loaded
// once that register is empty or its result is being taken by the receiver.
// One item is accepted per cycle while results are taken. When the receiver
// stalls, the result register holds its transaction and the input register
// keeps one more item; s_tready then falls until m_tready returns.
// Configuration registers are written through the cfg_ channel, which is
// always ready; writes to an index outside the register list are dropped.
// Reset clears the mode to disabled, the target, shot count and jam timer to
// zero, loads the default configuration and empties both registers.
module feed_rotor_jam_backoff_control (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// shot_count[15:0], motor_angle[47:16], motor_torque[63:48], tick_time_us[79:64]
	input  logic [79:0]                      s_tdata,
	// func[1:0]
	input  logic [1:0]                       s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// motor_ref[31:0], motor_command[33:32], mode[35:34], zero[39:36]
	output logic [39:0]                      m_tdata,
	// ref_valid[0]
	output logic [0:0]                       m_tuser,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [frjb_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [frjb_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import frjb_pkg::*;

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	state_t  state_q;
	state_t  state_next;
	result_t res;
	result_t res_s2;
	logic    valid_s2;
	logic    advance;

	frjb_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	frjb_update u_update (
		.item    (item_s1),
		.st      (state_q),
		.cfg     (cfg),
		.st_next (state_next),
		.res     (res)
	);

	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.func         <= s_tuser;
			item_s1.shot_count   <= s_tdata[15:0];
			item_s1.motor_angle  <= s_tdata[47:16];
			item_s1.motor_torque <= s_tdata[63:48];
			item_s1.tick_time_us <= s_tdata[79:64];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode             <= MODE_DISABLED;
			state_q.target_angle     <= 32'sd0;
			state_q.handled_sequence <= 16'd0;
			state_q.jam_timer        <= 32'd0;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || m_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {4'd0, res_s2.mode, res_s2.motor_command, res_s2.motor_ref};
	assign m_tuser  = res_s2.ref_valid;

`ifndef SYNTHESIS
	a_ref_not_disabled: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.ref_valid |->
			res_s2.mode != MODE_DISABLED && res_s2.motor_command == CMD_NONE)
		else $error("reference issued with a disabled mode or a motor command");

	a_start_normal: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.motor_command == CMD_START |-> res_s2.mode == MODE_NORMAL)
		else $error("start command without normal mode");

	a_stop_disabled: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.motor_command == CMD_STOP |-> res_s2.mode == MODE_DISABLED)
		else $error("stop command without disabled mode");

	a_mode_tracks_state: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2 && res_s2.mode == state_q.mode)
		else $error("result mode differs from controller state");
`endif

endmodule
